// File: rtl/core/swdq_pkg.sv
// Package for the sensor window debounce qualifier.
// Holds state codes, register indexes, reset values and the window compare.
// No dependencies.
package swdq_pkg;

    // Internal qualified state, one-hot
    typedef enum logic [2:0] {
        QS_IDLE   = 3'b001,
        QS_ACTIVE = 3'b010,
        QS_FAULT  = 3'b100
    } qstate_t;

    // Output state codes
    localparam logic [1:0] CODE_IDLE   = 2'd0;
    localparam logic [1:0] CODE_ACTIVE = 2'd1;
    localparam logic [1:0] CODE_FAULT  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_FAULT_WINDOW   = 3'd0;
    localparam logic [2:0] REG_DETECT_WINDOW  = 3'd1;
    localparam logic [2:0] REG_STANDBY_WINDOW = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE_MS    = 3'd3;
    localparam logic [2:0] REG_ON_DELAY_MS    = 3'd4;
    localparam logic [2:0] REG_OFF_DELAY_MS   = 3'd5;
    localparam logic [2:0] REG_MODE_BITS      = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register reset values
    localparam logic [31:0] FAULT_WINDOW_RST   = 32'h0000_0000;
    localparam logic [31:0] DETECT_WINDOW_RST  = 32'hFFFF_FFFF;
    localparam logic [31:0] STANDBY_WINDOW_RST = 32'hFFFF_0000;

    // Upper bound value that means "no upper bound"
    localparam logic [15:0] NO_UPPER = 16'hFFFF;

    // Mode bit positions
    localparam int MODE_EN  = 0;
    localparam int MODE_INV = 1;

    // Window membership: [15:0] min, [31:16] max, both inclusive
    function automatic logic in_window(
        input logic [15:0] v,
        input logic [31:0] win,
        input logic        open_top
    );
        logic [15:0] lo;
        logic [15:0] hi;
        lo = win[15:0];
        hi = win[31:16];
        return (v >= lo) && ((open_top && (hi == NO_UPPER)) || (v <= hi));
    endfunction

    function automatic logic [1:0] state_code(input qstate_t s);
        logic [1:0] c;
        unique case (s)
            QS_IDLE:   c = CODE_IDLE;
            QS_ACTIVE: c = CODE_ACTIVE;
            QS_FAULT:  c = CODE_FAULT;
            default:   c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/sensor_window_debounce_qualifier_core.sv
// Top level of the sensor window debounce qualifier.
// Input register, single-pass qualify logic, result register.
// Depends on swdq_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall carry one item (sample_mv, time_ms).
//   Output channel: out_valid / out_stall carry one result item per input
//   (channel_state: 0 idle, 1 active, 2 fault; state_changed).
//   Config port: cfg_we with cfg_index / cfg_data writes register cfg_index;
//   index 7 is ignored. Write only while the block is idle.
// Path: the accepting edge loads the input register; the result register
//   is loaded from it, with the qualified state, at the same edge that
//   updates the channel state, once no stalled result blocks it.
// Throughput: one item per cycle unless the output stalls; the state update
//   is combinational: window compares, three 32-bit elapsed-time subtractions.
// Reset: state idle, no debounce armed, timers not started, config at its
//   reset values (channel disabled).
// Stall: while out_stall holds a pending result, the result stays put and
//   the item in the input register waits; in_stall rises only when that
//   input register is also full.
module sensor_window_debounce_qualifier_core
    import swdq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            sample_mv,
    input  logic [31:0]            time_ms,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             channel_state,
    output logic                   state_changed
);

    // ---------------- configuration registers ----------------
    logic [31:0] fault_window_reg;
    logic [31:0] detect_window_reg;
    logic [31:0] standby_window_reg;
    logic [31:0] debounce_ms_reg;
    logic [31:0] on_delay_ms_reg;
    logic [31:0] off_delay_ms_reg;
    logic [1:0]  mode_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_window_reg   <= FAULT_WINDOW_RST;
            detect_window_reg  <= DETECT_WINDOW_RST;
            standby_window_reg <= STANDBY_WINDOW_RST;
            debounce_ms_reg    <= '0;
            on_delay_ms_reg    <= '0;
            off_delay_ms_reg   <= '0;
            mode_bits_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FAULT_WINDOW:   fault_window_reg   <= cfg_data;
                REG_DETECT_WINDOW:  detect_window_reg  <= cfg_data;
                REG_STANDBY_WINDOW: standby_window_reg <= cfg_data;
                REG_DEBOUNCE_MS:    debounce_ms_reg    <= cfg_data;
                REG_ON_DELAY_MS:    on_delay_ms_reg    <= cfg_data;
                REG_OFF_DELAY_MS:   off_delay_ms_reg   <= cfg_data;
                REG_MODE_BITS:      mode_bits_reg      <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic        s1_valid_reg;
    logic [15:0] s1_sample_reg;
    logic [31:0] s1_time_reg;
    logic        out_valid_reg;
    logic [1:0]  out_state_reg;
    logic        out_changed_reg;

    logic out_blocked;
    logic advance;
    logic in_take;

    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = s1_valid_reg && !out_blocked;   // item moves into result reg
    assign in_stall    = s1_valid_reg && out_blocked;
    assign in_take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (!out_blocked)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample_mv;
            s1_time_reg   <= time_ms;
        end
    end

    // ---------------- channel state ----------------
    qstate_t     cur_reg, cur_next;
    qstate_t     pend_reg, pend_next;
    logic        armed_reg, armed_next;
    logic [31:0] deb_start_reg, deb_start_next;
    logic [31:0] act_start_reg, act_start_next;
    logic [31:0] idle_start_reg, idle_start_next;

    logic        hit_fault, hit_detect, hit_standby;
    logic        raw_active, raw_fault, is_active;
    qstate_t     target;
    logic        stable, fin_active, fin_fault;
    logic [31:0] now;
    logic [31:0] deb_elapsed, on_elapsed, off_elapsed;
    logic [31:0] act_eff, idle_eff;

    assign now         = s1_time_reg;
    assign hit_fault   = (fault_window_reg != '0) &&
                         in_window(s1_sample_reg, fault_window_reg, 1'b1);
    assign hit_detect  = in_window(s1_sample_reg, detect_window_reg, 1'b1);
    assign hit_standby = in_window(s1_sample_reg, standby_window_reg, 1'b0);

    // zero start time means the timer has not started
    assign act_eff     = (act_start_reg == '0) ? now : act_start_reg;
    assign idle_eff    = (idle_start_reg == '0) ? now : idle_start_reg;
    assign on_elapsed  = now - act_eff;
    assign off_elapsed = now - idle_eff;
    assign deb_elapsed = now - deb_start_next;

    always_comb
    begin
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        armed_next      = armed_reg;
        deb_start_next  = deb_start_reg;
        act_start_next  = act_start_reg;
        idle_start_next = idle_start_reg;
        raw_active      = 1'b0;
        raw_fault       = 1'b0;
        is_active       = 1'b0;
        target          = QS_IDLE;
        stable          = 1'b1;
        fin_active      = 1'b0;
        fin_fault       = 1'b0;

        if (!mode_bits_reg[MODE_EN])
        begin
            cur_next = QS_IDLE;
        end
        else
        begin
            // window sort, fault first; between windows keeps last state
            priority if (hit_fault)
                raw_fault = 1'b1;
            else if (hit_detect)
                raw_active = 1'b1;
            else if (hit_standby)
                raw_active = 1'b0;
            else
            begin
                raw_active = (cur_reg == QS_ACTIVE);
                raw_fault  = (cur_reg == QS_FAULT);
            end

            is_active = mode_bits_reg[MODE_INV] ? (!raw_active && !raw_fault) : raw_active;
            target    = raw_fault ? QS_FAULT : (is_active ? QS_ACTIVE : QS_IDLE);

            if (pend_reg != target)
            begin
                armed_next     = 1'b1;
                pend_next      = target;
                deb_start_next = now;
            end

            stable     = !armed_next || (deb_elapsed >= debounce_ms_reg);
            fin_active = stable ? (target == QS_ACTIVE) : (cur_reg == QS_ACTIVE);
            fin_fault  = stable ? (target == QS_FAULT) : (cur_reg == QS_FAULT);

            priority if (fin_fault && cur_reg != QS_FAULT)
            begin
                cur_next = QS_FAULT;
            end
            else if (fin_active && cur_reg == QS_IDLE)
            begin
                act_start_next = act_eff;
                if (on_elapsed >= on_delay_ms_reg)
                begin
                    cur_next        = QS_ACTIVE;
                    idle_start_next = '0;
                end
            end
            else if (!fin_active && !fin_fault && cur_reg == QS_ACTIVE)
            begin
                idle_start_next = idle_eff;
                if (off_elapsed >= off_delay_ms_reg)
                begin
                    cur_next       = QS_IDLE;
                    act_start_next = '0;
                end
            end
            else
            begin
                if (fin_active)
                    idle_start_next = '0;
                else
                    act_start_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= QS_IDLE;
            pend_reg       <= QS_IDLE;
            armed_reg      <= 1'b0;
            deb_start_reg  <= '0;
            act_start_reg  <= '0;
            idle_start_reg <= '0;
        end
        else if (advance)
        begin
            cur_reg        <= cur_next;
            pend_reg       <= pend_next;
            armed_reg      <= armed_next;
            deb_start_reg  <= deb_start_next;
            act_start_reg  <= act_start_next;
            idle_start_reg <= idle_start_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg   <= state_code(cur_next);
            out_changed_reg <= (cur_next != cur_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_state = out_state_reg;
    assign state_changed = out_changed_reg;

endmodule

// File: rtl/core/swdq_checker.sv
// Port-level checker for the sensor window debounce qualifier.
// Bound to sensor_window_debounce_qualifier_core; depends on swdq_pkg.
module swdq_checker
    import swdq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [1:0]             channel_state,
    input logic                   state_changed
);

    // last delivered state, idle after reset
    logic [1:0] last_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_state_reg <= CODE_IDLE;
        else if (out_valid && !out_stall)
            last_state_reg <= channel_state;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel_state)
            && $stable(state_changed))
        else $error("stalled result changed");

    // input only backs up behind a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // changed flag agrees with the sequence of delivered states
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_changed == (channel_state != last_state_reg))
        else $error("state_changed does not match state sequence");

    // fault is left only by disabling, which lands in idle
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_state_reg == CODE_FAULT && channel_state != CODE_FAULT
            |-> channel_state == CODE_IDLE)
        else $error("fault left to a state other than idle");

endmodule

bind sensor_window_debounce_qualifier_core swdq_checker u_swdq_checker (.*);

// File: tb/sv/swdq_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sensor window debounce qualifier testbench: register
// mirror, channel state predictor and queue of expected result items.
// Depends on swdq_pkg.
package swdq_tb_pkg;

    import swdq_pkg::*;

    typedef struct {
        logic [1:0]  state;
        logic        changed;
        logic [15:0] mv;
        logic [31:0] stamp;
    } qual_result_t;

    class channel_state_checker;

        // register mirror
        logic [31:0] fault_win;
        logic [31:0] detect_win;
        logic [31:0] standby_win;
        logic [31:0] debounce_ms;
        logic [31:0] on_delay_ms;
        logic [31:0] off_delay_ms;
        logic [1:0]  mode;

        // channel state
        logic [1:0]  cur_state;
        logic [1:0]  pend_target;
        logic        armed;
        logic [31:0] deb_start;
        logic [31:0] act_start;
        logic [31:0] idle_start;

        qual_result_t pending_states[$];
        int unsigned  mismatches;

        function new();
            fault_win    = FAULT_WINDOW_RST;
            detect_win   = DETECT_WINDOW_RST;
            standby_win  = STANDBY_WINDOW_RST;
            debounce_ms  = '0;
            on_delay_ms  = '0;
            off_delay_ms = '0;
            mode         = '0;
            cur_state    = CODE_IDLE;
            pend_target  = CODE_IDLE;
            armed        = 1'b0;
            deb_start    = '0;
            act_start    = '0;
            idle_start   = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_FAULT_WINDOW:   fault_win    = data;
                REG_DETECT_WINDOW:  detect_win   = data;
                REG_STANDBY_WINDOW: standby_win  = data;
                REG_DEBOUNCE_MS:    debounce_ms  = data;
                REG_ON_DELAY_MS:    on_delay_ms  = data;
                REG_OFF_DELAY_MS:   off_delay_ms = data;
                REG_MODE_BITS:      mode         = data[1:0];
                default:            ;
            endcase
        endfunction

        // open_top: a max of all ones lifts the upper bound
        function bit falls_in(logic [15:0] mv, logic [31:0] win, bit open_top);
            bit above_min;
            bit below_max;
            above_min = (mv >= win[15:0]);
            below_max = (open_top && (win[31:16] == NO_UPPER)) || (mv <= win[31:16]);
            return above_min && below_max;
        endfunction

        function void qualify_sample(logic [15:0] mv, logic [31:0] now);
            logic [1:0]   prior;
            logic [1:0]   tgt;
            logic [31:0]  elapsed;
            bit           act;
            bit           flt;
            bit           settled;
            bit           want_act;
            bit           want_flt;
            qual_result_t res;
            prior = cur_state;
            if (!mode[MODE_EN]) begin
                cur_state = CODE_IDLE;
            end
            else begin
                act = 1'b0;
                flt = 1'b0;
                if ((fault_win != '0) && falls_in(mv, fault_win, 1'b1))
                    flt = 1'b1;
                else if (falls_in(mv, detect_win, 1'b1))
                    act = 1'b1;
                else if (!falls_in(mv, standby_win, 1'b0))
                begin
                    // between windows: last qualified state stands
                    act = (cur_state == CODE_ACTIVE);
                    flt = (cur_state == CODE_FAULT);
                end
                if (mode[MODE_INV])
                    act = !act && !flt;
                tgt = flt ? CODE_FAULT : (act ? CODE_ACTIVE : CODE_IDLE);
                if (tgt != pend_target)
                begin
                    pend_target = tgt;
                    armed       = 1'b1;
                    deb_start   = now;
                end
                elapsed  = now - deb_start;
                settled  = !armed || (elapsed >= debounce_ms);
                want_act = settled ? (tgt == CODE_ACTIVE) : (cur_state == CODE_ACTIVE);
                want_flt = settled ? (tgt == CODE_FAULT) : (cur_state == CODE_FAULT);
                if (want_flt && (cur_state != CODE_FAULT)) begin
                    cur_state = CODE_FAULT;
                end
                else if (want_act && (cur_state == CODE_IDLE)) begin
                    if (act_start == '0)
                        act_start = now;
                    elapsed = now - act_start;
                    if (elapsed >= on_delay_ms)
                    begin
                        cur_state  = CODE_ACTIVE;
                        idle_start = '0;
                    end
                end
                else if (!want_act && !want_flt && (cur_state == CODE_ACTIVE)) begin
                    if (idle_start == '0)
                        idle_start = now;
                    elapsed = now - idle_start;
                    if (elapsed >= off_delay_ms)
                    begin
                        cur_state = CODE_IDLE;
                        act_start = '0;
                    end
                end
                else if (want_act) begin
                    idle_start = '0;
                end
                else begin
                    act_start = '0;
                end
            end
            res.state   = cur_state;
            res.changed = (cur_state != prior);
            res.mv      = mv;
            res.stamp   = now;
            pending_states.push_back(res);
        endfunction

        function void check_state(logic [1:0] st, logic chg);
            qual_result_t want;
            if (pending_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: state %0d changed %0d", st, chg);
                return;
            end
            want = pending_states.pop_front();
            if ((st !== want.state) || (chg !== want.changed)) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch (sample %0d, time %0d): ", want.mv, want.stamp);
                    $display("state exp %0d got %0d, changed exp %0d got %0d",
                             want.state, st, want.changed, chg);
                end
            end
        endfunction

        function int backlog();
            return pending_states.size();
        endfunction

    endclass

endpackage

// File: tb/sv/sensor_window_debounce_qualifier_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for sensor_window_debounce_qualifier_core: directed and
// random samples under random input gaps and output stalls, checked live.
// Depends on swdq_pkg, swdq_tb_pkg and the RTL.
module sensor_window_debounce_qualifier_core_tb;

    import swdq_pkg::*;
    import swdq_tb_pkg::*;

    // mode register values
    localparam logic [31:0] MODE_OFF    = 32'd0;
    localparam logic [31:0] MODE_ON     = 32'd1;
    localparam logic [31:0] MODE_ON_INV = 32'd3;

    localparam int QUIET_LIMIT  = 1000; // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_AT      = 210;  // items in before the long back-pressure
    localparam int HOLD_CYCLES  = 80;

    typedef enum {RG_STANDBY, RG_GAP, RG_DETECT, RG_FAULT, RG_EDGE, RG_ANY} region_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            sample_mv;
    logic [31:0]            time_ms;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             channel_state;
    logic                   state_changed;

    channel_state_checker sb = new();

    int unsigned items_in    = 0;
    int unsigned quiet_cycles = 0;
    bit          hold_active = 1'b0;
    bit          hold_done   = 1'b0;
    logic [31:0] ms_now      = '0;   // running timestamp of the sample stream

    sensor_window_debounce_qualifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_mv     (sample_mv),
        .time_ms       (time_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_state (channel_state),
        .state_changed (state_changed)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Handshakes are sampled at the rising edge, before the block's own
    // register updates land, so both sides see the same pre-edge values.
    // Input is noted first; a result at the same edge always belongs to an
    // older item, since an item reaches the result register from the input register.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.qualify_sample(sample_mv, time_ms);
                items_in++;
            end
            if (out_valid && !out_stall)
                sb.check_state(channel_state, state_changed);
        end
    end

    // Watchdog: any stretch with no accepted item on either side this long
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL sensor_window_debounce_qualifier_core");
            $finish;
        end
    end

    // Receiver: switches between free flow, light random stalls, a periodic
    // pattern and heavy stalls. Once enough items are in, it holds off for a
    // long stretch so the result and input registers both fill and in_stall
    // rises; the sender runs gapless meanwhile.
    initial
    begin
        int span;
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!hold_done && (items_in >= HOLD_AT)) begin
                hold_active = 1'b1;
                out_stall   = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall   = 1'b0;
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            else begin
                span = $urandom_range(40, 5);
                case ($urandom_range(3, 0))
                    0: begin
                        out_stall = 1'b0;
                        repeat (span) @(negedge clk);
                    end
                    1: repeat (span) begin
                        out_stall = ($urandom_range(99, 0) < 35);
                        @(negedge clk);
                    end
                    2: begin
                        k = $urandom_range(5, 2);
                        for (int i = 0; i < span; i++) begin
                            out_stall = ((i % k) == 0);
                            @(negedge clk);
                        end
                    end
                    default: repeat (span) begin
                        out_stall = ($urandom_range(99, 0) < 80);
                        @(negedge clk);
                    end
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted; returns at the next falling
    // edge with in_valid still high, so the caller either offers the next
    // item right away or drops valid.
    task automatic push_sample(input logic [15:0] mv, input logic [31:0] t);
        in_valid  = 1'b1;
        sample_mv = mv;
        time_ms   = t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_input(input int n);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Register write, only once every expected result is out and the
    // pipeline has had time to empty.
    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        in_valid = 1'b0;
        while (sb.backlog() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_config(input logic [31:0] fw, input logic [31:0] dw,
                               input logic [31:0] sw, input logic [31:0] deb,
                               input logic [31:0] on_d, input logic [31:0] off_d,
                               input logic [31:0] mode_word);
        set_reg(REG_FAULT_WINDOW, fw);
        set_reg(REG_DETECT_WINDOW, dw);
        set_reg(REG_STANDBY_WINDOW, sw);
        set_reg(REG_DEBOUNCE_MS, deb);
        set_reg(REG_ON_DELAY_MS, on_d);
        set_reg(REG_OFF_DELAY_MS, off_d);
        set_reg(REG_MODE_BITS, mode_word);
    endtask

    function automatic logic [15:0] draw_in_window(logic [31:0] win);
        if (win[15:0] <= win[31:16])
            return 16'($urandom_range(win[31:16], win[15:0]));
        return 16'($urandom_range(65535, 0));
    endfunction

    // window bounds, one past them, and the field extremes
    function automatic logic [15:0] draw_edge();
        logic [31:0] w;
        case ($urandom_range(2, 0))
            0:       w = sb.fault_win;
            1:       w = sb.detect_win;
            default: w = sb.standby_win;
        endcase
        case ($urandom_range(5, 0))
            0:       return w[15:0];
            1:       return w[31:16];
            2:       return w[15:0] - 16'd1;
            3:       return w[31:16] + 16'd1;
            4:       return 16'd0;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] draw_sample(region_t rg);
        logic [16:0] lo;
        logic [16:0] hi;
        case (rg)
            RG_STANDBY: return draw_in_window(sb.standby_win);
            RG_DETECT:  return draw_in_window(sb.detect_win);
            RG_FAULT:   return (sb.fault_win != '0) ? draw_in_window(sb.fault_win)
                                                    : 16'($urandom_range(65535, 0));
            RG_GAP: begin
                // strictly between the standby top and the detect bottom
                lo = {1'b0, sb.standby_win[31:16]} + 17'd1;
                hi = {1'b0, sb.detect_win[15:0]};
                if (lo < hi)
                    return 16'($urandom_range(hi - 1, lo));
                return 16'($urandom_range(65535, 0));
            end
            RG_EDGE:    return draw_edge();
            default:    return 16'($urandom_range(65535, 0));
        endcase
    endfunction

    // Mostly a forward-running clock; now and then a random jump, a restart
    // at zero, a spot just short of the wrap, or a step backward.
    function automatic logic [31:0] next_stamp(int step_max);
        int r;
        r = $urandom_range(99, 0);
        if (r < 80)
            ms_now = ms_now + $urandom_range(step_max, 0);
        else if (r < 86)
            ms_now = $urandom;
        else if (r < 90)
            ms_now = '0;
        else if (r < 95)
            ms_now = 32'hFFFF_FFFF - $urandom_range(2 * step_max, 0);
        else
            ms_now = ms_now - $urandom_range(step_max, 1);
        return ms_now;
    endfunction

    // Mostly short timers so transitions complete; rarely zero or all ones.
    function automatic logic [31:0] draw_ms();
        int r;
        r = $urandom_range(99, 0);
        if (r < 15)
            return '0;
        if (r < 20)
            return 32'hFFFF_FFFF;
        return $urandom_range(30, 1);
    endfunction

    // Windows stacked from the bottom: standby, a gap, detect, then fault.
    task automatic random_config();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        int unsigned e;
        int unsigned f;
        logic [31:0] fw;
        logic [31:0] dw;
        logic [31:0] sw;
        logic [31:0] mw;
        int          r;
        a  = $urandom_range(20000, 0);
        e  = $urandom_range(a, 0);
        b  = a + $urandom_range(8000, 2);
        c  = b + $urandom_range(8000, 0);
        d  = c + $urandom_range(8000, 1);
        f  = d + $urandom_range(5000, 0);
        sw = {a[15:0], e[15:0]};
        dw = ($urandom_range(1, 0) != 0) ? {16'hFFFF, b[15:0]} : {c[15:0], b[15:0]};
        case ($urandom_range(3, 0))
            0:       fw = '0;
            1:       fw = {16'hFFFF, d[15:0]};
            2:       fw = {f[15:0], d[15:0]};
            default: fw = $urandom;
        endcase
        r = $urandom_range(99, 0);
        if (r < 70)
            mw = MODE_ON;
        else if (r < 92)
            mw = MODE_ON_INV;
        else
            mw = {30'd0, 1'($urandom_range(1, 0)), 1'b0}; // channel off, invert either way
        load_config(fw, dw, sw, draw_ms(), draw_ms(), draw_ms(), mw);
    endtask

    // Runs of samples from one region give the target time to settle through
    // the debounce and delay timers; edge and anywhere runs are the noise.
    task automatic random_phase(input int n_items, input int step_max, input bit no_gaps);
        int      left;
        int      burst;
        int      run;
        int      gap;
        int      r;
        region_t rg;
        left  = n_items;
        burst = $urandom_range(20, 1);
        run   = 0;
        rg    = RG_STANDBY;
        while (left > 0) begin
            if (run == 0) begin
                r = $urandom_range(99, 0);
                if (r < 25)      rg = RG_STANDBY;
                else if (r < 35) rg = RG_GAP;
                else if (r < 65) rg = RG_DETECT;
                else if (r < 80) rg = RG_FAULT;
                else if (r < 90) rg = RG_EDGE;
                else             rg = RG_ANY;
                run = $urandom_range(12, 1);
            end
            push_sample(draw_sample(rg), next_stamp(step_max));
            run--;
            left--;
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(20, 1);
                gap   = $urandom_range(8, 0);
                if (!no_gaps && !hold_active && (gap > 0))
                    idle_input(gap);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample_mv = '0;
        time_ms   = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Channel is disabled out of reset: idle whatever the sample.
        push_sample(16'd100, 32'd5);
        push_sample(16'hFFFF, 32'd6);

        // standby 0..999, detect 2000 and up, fault 60000 and up
        load_config(32'hFFFF_EA60, 32'hFFFF_07D0, 32'h03E7_0000,
                    32'd5, 32'd10, 32'd10, MODE_ON);
        push_sample(16'd500, 32'd0);
        push_sample(16'd3000, 32'd0);     // arms debounce
        push_sample(16'd3000, 32'd10);    // debounced, on delay starts
        push_sample(16'd3000, 32'd20);    // goes active
        push_sample(16'd1500, 32'd25);    // between windows, stays active
        push_sample(16'd500, 32'd30);
        push_sample(16'd500, 32'd40);     // off delay starts
        push_sample(16'd500, 32'd50);     // back to idle
        push_sample(16'hFFFF, 32'd55);
        push_sample(16'hFFFF, 32'd60);    // fault
        push_sample(16'd500, 32'd100);    // fault is sticky
        push_sample(16'd3000, 32'd200);

        // disabling is the only way out of fault
        set_reg(REG_MODE_BITS, MODE_OFF);
        push_sample(16'd0, 32'd210);

        // no fault window, bounded detect 2000..4000, zero debounce;
        // on delay started at time zero gets restarted
        load_config(32'h0000_0000, 32'h0FA0_07D0, 32'h03E7_0000,
                    32'd0, 32'd10, 32'd10, MODE_ON);
        push_sample(16'd3000, 32'd0);
        push_sample(16'd3000, 32'd5);
        push_sample(16'd3000, 32'd12);
        push_sample(16'd3000, 32'd15);
        push_sample(16'hFFFF, 32'd16);    // above bounded detect: holds
        push_sample(16'd0, 32'hFFFF_FFF8);
        push_sample(16'd0, 32'h0000_0004); // off delay measured across wrap

        // inverted sense
        set_reg(REG_MODE_BITS, MODE_ON_INV);
        push_sample(16'd3000, 32'd100);
        push_sample(16'd500, 32'd101);
        push_sample(16'd500, 32'd200);

        for (int p = 0; p < 6; p++) begin
            random_config();
            random_phase(60, $urandom_range(40, 1), p == 2);
        end

        // all registers at all ones
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(30, 40, 1'b0);

        // all windows and timers at zero
        load_config('0, '0, '0, '0, '0, '0, MODE_ON);
        random_phase(30, 10, 1'b0);

        in_valid = 1'b0;
        while (sb.backlog() != 0) @(negedge clk);
        repeat (4 * DRAIN_CYCLES) @(negedge clk);
        if ((sb.mismatches == 0) && (sb.backlog() == 0))
            $display("PASS sensor_window_debounce_qualifier_core");
        else
            $display("FAIL sensor_window_debounce_qualifier_core");
        $finish;
    end

endmodule
